// File: hdl/vbg_pkg.sv
// Shared types and constants for the volume block gather address generator.
package vbg_pkg;

    localparam int AXIS_W  = 16;
    localparam int START_W = 20;
    localparam int PROD_W  = 32;
    localparam int SRC_W   = 48;
    localparam int DST_W   = 9;
    localparam int LEN_W   = 4;
    localparam int EDGE_W  = 4;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DATA_W = 16;
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = 2;
    localparam int QCNT_W  = 3;

    localparam logic [CFG_IDX_W-1:0] REG_SIZE_X   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_LEN = 4'd3;

    typedef struct packed {
        logic [SRC_W-1:0]  start;
        logic [LEN_W-1:0]  nx;
        logic [LEN_W-1:0]  ny;
        logic [LEN_W-1:0]  nz;
        logic [EDGE_W-1:0] edge_len;
    } job_t;

endpackage

// File: hdl/vbg_front.sv
// Front end: accepts block requests, computes clip counts and block start index.
module vbg_front
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [vbg_pkg::AXIS_W-1:0]     bx,
    input  logic [vbg_pkg::AXIS_W-1:0]     by,
    input  logic [vbg_pkg::AXIS_W-1:0]     bz,
    input  logic [vbg_pkg::EDGE_W-1:0]     edge_len,
    input  logic [vbg_pkg::AXIS_W-1:0]     dx,
    input  logic [vbg_pkg::AXIS_W-1:0]     dy,
    input  logic [vbg_pkg::AXIS_W-1:0]     dz,
    input  logic [vbg_pkg::PROD_W-1:0]     prod_yz,
    output logic                           push_valid,
    input  logic                           push_ready,
    output vbg_pkg::job_t                  push_job
);

    function automatic logic [vbg_pkg::LEN_W-1:0] valid_cnt(
        input logic [vbg_pkg::START_W-1:0] start,
        input logic [vbg_pkg::AXIS_W-1:0]  ext,
        input logic [vbg_pkg::EDGE_W-1:0]  edge_v
    );
        logic [vbg_pkg::START_W-1:0] ext_w;
        logic [vbg_pkg::START_W-1:0] room;
        logic [vbg_pkg::LEN_W-1:0]   res;
        ext_w = vbg_pkg::START_W'(ext);
        room  = ext_w - start;
        if (start >= ext_w)
            res = '0;
        else if (room < vbg_pkg::START_W'(edge_v))
            res = room[vbg_pkg::LEN_W-1:0];
        else
            res = edge_v;
        return res;
    endfunction

    // stage 1: block origin
    logic                          s1_valid_reg;
    logic [vbg_pkg::START_W-1:0]   x0_reg, y0_reg, z0_reg;
    logic [vbg_pkg::EDGE_W-1:0]    edge1_reg;
    // stage 2: clip counts and partial products
    logic                          s2_valid_reg;
    logic [vbg_pkg::LEN_W-1:0]     nx_reg, ny_reg, nz_reg;
    logic [vbg_pkg::SRC_W-1:0]     xp_reg;
    logic [vbg_pkg::PROD_W-1:0]    ydz_reg;
    logic [vbg_pkg::AXIS_W-1:0]    z0s_reg;
    logic [vbg_pkg::EDGE_W-1:0]    edge2_reg;

    logic s1_ready, s2_ready, s1_load, s2_load;

    assign s2_ready = !s2_valid_reg || push_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_stall = !s1_ready;
    assign s1_load  = in_valid && s1_ready;
    assign s2_load  = s1_valid_reg && s2_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= in_valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            x0_reg    <= vbg_pkg::START_W'(bx) * vbg_pkg::START_W'(edge_len);
            y0_reg    <= vbg_pkg::START_W'(by) * vbg_pkg::START_W'(edge_len);
            z0_reg    <= vbg_pkg::START_W'(bz) * vbg_pkg::START_W'(edge_len);
            edge1_reg <= edge_len;
        end
        if (s2_load)
        begin
            nx_reg    <= valid_cnt(x0_reg, dx, edge1_reg);
            ny_reg    <= valid_cnt(y0_reg, dy, edge1_reg);
            nz_reg    <= valid_cnt(z0_reg, dz, edge1_reg);
            xp_reg    <= vbg_pkg::SRC_W'(x0_reg[vbg_pkg::AXIS_W-1:0])
                         * vbg_pkg::SRC_W'(prod_yz);
            ydz_reg   <= vbg_pkg::PROD_W'(y0_reg[vbg_pkg::AXIS_W-1:0])
                         * vbg_pkg::PROD_W'(dz);
            z0s_reg   <= z0_reg[vbg_pkg::AXIS_W-1:0];
            edge2_reg <= edge1_reg;
        end
    end

    always_comb
    begin
        push_valid        = s2_valid_reg;
        push_job.start    = xp_reg + vbg_pkg::SRC_W'(ydz_reg) + vbg_pkg::SRC_W'(z0s_reg);
        push_job.nx       = nx_reg;
        push_job.ny       = ny_reg;
        push_job.nz       = nz_reg;
        push_job.edge_len = edge2_reg;
    end

endmodule

// File: hdl/vbg_queue.sv
// Short job queue between the front end and the row walker.
module vbg_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  vbg_pkg::job_t  push_job,
    output logic           pop_valid,
    input  logic           pop,
    output vbg_pkg::job_t  head_job
);

    vbg_pkg::job_t                 entry_reg [vbg_pkg::QDEPTH];
    logic [vbg_pkg::QPTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [vbg_pkg::QCNT_W-1:0]    count_reg;
    logic                          do_push, do_pop;

    assign push_ready = count_reg != vbg_pkg::QCNT_W'(vbg_pkg::QDEPTH);
    assign pop_valid  = count_reg != '0;
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;
    assign head_job   = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

endmodule

// File: hdl/vbg_back.sv
// Row walker: steps through the rows of the head job and drives the output register.
module vbg_back #(
    parameter int MAX_EDGE = 8
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          job_valid,
    input  vbg_pkg::job_t                 job,
    output logic                          job_pop,
    input  logic [vbg_pkg::AXIS_W-1:0]    dz,
    input  logic [vbg_pkg::PROD_W-1:0]    prod_yz,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [vbg_pkg::SRC_W-1:0]     src_index,
    output logic [vbg_pkg::DST_W-1:0]     dst_offset,
    output logic [vbg_pkg::LEN_W-1:0]     copy_len,
    output logic                          last_row
);

    localparam int CW = (MAX_EDGE > 1) ? $clog2(MAX_EDGE) : 1;

    logic [CW-1:0]               lx_reg, ly_reg, lx_next, ly_next;
    logic                        fresh_reg, fresh_next;
    logic [vbg_pkg::SRC_W-1:0]   plane_reg, row_reg, plane_next, row_next;
    logic [vbg_pkg::SRC_W-1:0]   plane_cur, row_cur;
    logic [vbg_pkg::DST_W-1:0]   dst_reg, dst_next, dst_cur;
    logic                        out_valid_reg;
    logic [vbg_pkg::SRC_W-1:0]   src_reg;
    logic [vbg_pkg::DST_W-1:0]   dsto_reg;
    logic [vbg_pkg::LEN_W-1:0]   len_reg;
    logic                        last_reg;
    logic                        advance, end_x, end_y, copy;
    logic [vbg_pkg::EDGE_W-1:0]  edge_m1;

    assign advance   = job_valid && (!out_valid_reg || !out_stall);
    assign edge_m1   = job.edge_len - 4'd1;
    assign end_y     = vbg_pkg::EDGE_W'(ly_reg) == edge_m1;
    assign end_x     = vbg_pkg::EDGE_W'(lx_reg) == edge_m1;
    assign copy      = (vbg_pkg::LEN_W'(lx_reg) < job.nx) && (vbg_pkg::LEN_W'(ly_reg) < job.ny)
                       && (job.nz != '0);
    assign plane_cur = fresh_reg ? job.start : plane_reg;
    assign row_cur   = fresh_reg ? job.start : row_reg;
    assign dst_cur   = fresh_reg ? '0 : dst_reg;
    assign job_pop   = advance && end_x && end_y;

    always_comb
    begin
        lx_next    = lx_reg;
        ly_next    = ly_reg;
        fresh_next = fresh_reg;
        plane_next = plane_reg;
        row_next   = row_reg;
        dst_next   = dst_reg;
        if (advance)
        begin
            fresh_next = 1'b0;
            dst_next   = dst_cur + vbg_pkg::DST_W'(job.edge_len);
            plane_next = plane_cur;
            row_next   = row_cur + vbg_pkg::SRC_W'(dz);
            ly_next    = ly_reg + 1'b1;
            if (end_y)
            begin
                ly_next    = '0;
                lx_next    = lx_reg + 1'b1;
                plane_next = plane_cur + vbg_pkg::SRC_W'(prod_yz);
                row_next   = plane_cur + vbg_pkg::SRC_W'(prod_yz);
                if (end_x)
                begin
                    lx_next    = '0;
                    fresh_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lx_reg        <= '0;
            ly_reg        <= '0;
            fresh_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            lx_reg    <= lx_next;
            ly_reg    <= ly_next;
            fresh_reg <= fresh_next;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        plane_reg <= plane_next;
        row_reg   <= row_next;
        dst_reg   <= dst_next;
        if (advance)
        begin
            src_reg  <= copy ? row_cur : '0;
            dsto_reg <= dst_cur;
            len_reg  <= copy ? job.nz : '0;
            last_reg <= end_x && end_y;
        end
    end

    assign out_valid  = out_valid_reg;
    assign src_index  = src_reg;
    assign dst_offset = dsto_reg;
    assign copy_len   = len_reg;
    assign last_row   = last_reg;

endmodule

// File: hdl/volume_block_gather_address_gen_top.sv
// Top level of the volume block gather address generator.
//
// Input channel (in_valid/in_stall) transfers one block request: blk_x, blk_y,
// blk_z. Output channel (out_valid/out_stall) transfers one row descriptor per
// row of the block: edge_len*edge_len descriptors per request, x-major, with
// last_row set on the final one. Rows outside the volume have copy_len 0 and
// src_index 0.
// Throughput: one descriptor per cycle from the row walker while a job is queued
// and out_stall is low; requests follow each other with no gap.
// The first descriptor passes the front stage 1 and stage 2 registers, the job
// queue and the output register.
// A four-entry job queue decouples the front end, which keeps taking requests
// while the walker works, from the walker.
// Out_stall holds the output register; the walker and then the front end
// back up behind it without losing anything.
// Reset clears the pipeline, the queue and the walker and sets the registers
// to size 1x1x1 and edge 8. Configuration writes (cfg_we) are taken any time
// and must be made while the block is idle.
module volume_block_gather_address_gen_top #(
    parameter int MAX_EDGE   = 8
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [vbg_pkg::AXIS_W-1:0]        blk_x,
    input  logic [vbg_pkg::AXIS_W-1:0]        blk_y,
    input  logic [vbg_pkg::AXIS_W-1:0]        blk_z,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [vbg_pkg::SRC_W-1:0]         src_index,
    output logic [vbg_pkg::DST_W-1:0]         dst_offset,
    output logic [vbg_pkg::LEN_W-1:0]         copy_len,
    output logic                              last_row,
    input  logic                              cfg_we,
    input  logic [vbg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [vbg_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam logic [vbg_pkg::EDGE_W-1:0] MAXE = vbg_pkg::EDGE_W'(MAX_EDGE);

    logic [vbg_pkg::AXIS_W-1:0]   size_x_reg, size_y_reg, size_z_reg;
    logic [vbg_pkg::EDGE_W-1:0]   edge_reg, edge_eff;
    logic [vbg_pkg::AXIS_W-1:0]   dx, dy, dz;
    logic [vbg_pkg::PROD_W-1:0]   prod_reg;

    logic           push_valid, push_ready, pop_valid, pop;
    vbg_pkg::job_t  push_job, head_job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg <= 16'd1;
            size_y_reg <= 16'd1;
            size_z_reg <= 16'd1;
            edge_reg   <= 4'd8;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                vbg_pkg::REG_SIZE_X:   size_x_reg <= cfg_data;
                vbg_pkg::REG_SIZE_Y:   size_y_reg <= cfg_data;
                vbg_pkg::REG_SIZE_Z:   size_z_reg <= cfg_data;
                vbg_pkg::REG_EDGE_LEN: edge_reg   <= cfg_data[vbg_pkg::EDGE_W-1:0];
                default: ;
            endcase
        end
    end

    assign dx = size_x_reg;
    assign dy = size_y_reg;
    assign dz = size_z_reg;

    always_comb
    begin
        if (edge_reg == '0)
            edge_eff = 4'd1;
        else if (edge_reg > MAXE)
            edge_eff = MAXE;
        else
            edge_eff = edge_reg;
    end

    // y-z plane size
    always_ff @(posedge clk)
    begin
        prod_reg <= vbg_pkg::PROD_W'(dy) * vbg_pkg::PROD_W'(dz);
    end

    vbg_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .bx         (blk_x),
        .by         (blk_y),
        .bz         (blk_z),
        .edge_len   (edge_eff),
        .dx         (dx),
        .dy         (dy),
        .dz         (dz),
        .prod_yz    (prod_reg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    vbg_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .head_job   (head_job)
    );

    vbg_back #(
        .MAX_EDGE (MAX_EDGE)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (pop_valid),
        .job        (head_job),
        .job_pop    (pop),
        .dz         (dz),
        .prod_yz    (prod_reg),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .src_index  (src_index),
        .dst_offset (dst_offset),
        .copy_len   (copy_len),
        .last_row   (last_row)
    );

endmodule

// File: bench/tb_volume_block_gather_address_gen_top.sv
// Self-checking bench: block requests in, row copy descriptors checked against a predictor.
module tb_volume_block_gather_address_gen_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_EDGE       = 8;
    localparam int SETTLE_CYCLES  = 6;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PLAN_LEN       = 25;
    localparam int PHASES         = 10;
    localparam int PHASE_ITEMS    = 26;

    typedef struct packed {
        logic [vbg_pkg::SRC_W-1:0] src;
        logic [vbg_pkg::DST_W-1:0] dst;
        logic [vbg_pkg::LEN_W-1:0] len;
        logic                      last;
    } row_t;

    typedef struct packed {
        bit                        set_cfg;
        logic [15:0]               sx;
        logic [15:0]               sy;
        logic [15:0]               sz;
        logic [15:0]               ed;
        logic [15:0]               bx;
        logic [15:0]               by;
        logic [15:0]               bz;
        bit                        known;
        logic [vbg_pkg::SRC_W-1:0] k_src;
        logic [vbg_pkg::LEN_W-1:0] k_len;
    } plan_row_t;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_stall;
    logic [vbg_pkg::AXIS_W-1:0]     blk_x;
    logic [vbg_pkg::AXIS_W-1:0]     blk_y;
    logic [vbg_pkg::AXIS_W-1:0]     blk_z;
    logic                           out_valid;
    logic                           out_stall;
    logic [vbg_pkg::SRC_W-1:0]      src_index;
    logic [vbg_pkg::DST_W-1:0]      dst_offset;
    logic [vbg_pkg::LEN_W-1:0]      copy_len;
    logic                           last_row;
    logic                           cfg_we;
    logic [vbg_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [vbg_pkg::CFG_DATA_W-1:0] cfg_data;

    // known first-row values travel with the request
    bit                             tag_known;
    logic [vbg_pkg::SRC_W-1:0]      tag_src;
    logic [vbg_pkg::LEN_W-1:0]      tag_len;

    logic [15:0]           cur_sx   = 16'd1;
    logic [15:0]           cur_sy   = 16'd1;
    logic [15:0]           cur_sz   = 16'd1;
    logic [3:0]            cur_edge = 4'd8;

    row_t                  rows_due [$];
    int                    errors       = 0;
    int                    rows_checked = 0;
    int                    blocks_sent  = 0;
    int                    settings_used = 0;
    int                    quiet_cycles = 0;
    bit                    no_idle = 1'b0;

    plan_row_t plan [0:PLAN_LEN-1] = '{
        '{0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 1},
        '{0, 0, 0, 0, 0, 1, 0, 0, 1, 0, 0},
        '{0, 0, 0, 0, 0, 'hFFFF, 'hFFFF, 'hFFFF, 1, 0, 0},
        '{1, 'hFFFF, 'hFFFF, 'hFFFF, 8, 0, 0, 0, 1, 0, 8},
        '{0, 0, 0, 0, 0, 8191, 8191, 8191, 0, 0, 0},
        '{0, 0, 0, 0, 0, 8191, 0, 8191, 0, 0, 0},
        '{0, 0, 0, 0, 0, 'hFFFF, 'hFFFF, 'hFFFF, 1, 0, 0},
        '{0, 0, 0, 0, 0, 8192, 0, 0, 1, 0, 0},
        '{1, 5, 6, 7, 'hFFF0, 0, 0, 0, 1, 0, 1},
        '{0, 0, 0, 0, 0, 4, 5, 6, 0, 0, 0},
        '{0, 0, 0, 0, 0, 5, 0, 0, 1, 0, 0},
        '{0, 0, 0, 0, 0, 0, 0, 6, 0, 0, 0},
        '{1, 20, 10, 3, 'hFFFF, 0, 0, 0, 1, 0, 3},
        '{0, 0, 0, 0, 0, 2, 1, 0, 0, 0, 0},
        '{0, 0, 0, 0, 0, 0, 0, 1, 1, 0, 0},
        '{1, 0, 4, 4, 4, 0, 0, 0, 1, 0, 0},
        '{1, 4, 0, 4, 3, 0, 0, 0, 1, 0, 0},
        '{1, 4, 4, 0, 2, 0, 0, 0, 1, 0, 0},
        '{1, 9, 9, 9, 3, 0, 0, 0, 1, 0, 3},
        '{0, 0, 0, 0, 0, 2, 2, 2, 0, 0, 0},
        '{0, 0, 0, 0, 0, 1, 2, 0, 0, 0, 0},
        '{1, 12, 7, 11, 5, 2, 1, 2, 0, 0, 0},
        '{0, 0, 0, 0, 0, 1, 0, 1, 0, 0, 0},
        '{1, 'hFFFF, 1, 'hFFFF, 1, 'hFFFE, 0, 'hFFFE, 0, 0, 0},
        '{0, 0, 0, 0, 0, 'hFFFF, 0, 'hFFFF, 1, 0, 0}
    };

    volume_block_gather_address_gen_top DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .blk_x      (blk_x),
        .blk_y      (blk_y),
        .blk_z      (blk_z),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .src_index  (src_index),
        .dst_offset (dst_offset),
        .copy_len   (copy_len),
        .last_row   (last_row),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [63:0] edge_used();
        if (cur_edge == 4'd0)
            return 64'd1;
        if (cur_edge > MAX_EDGE)
            return 64'(MAX_EDGE);
        return 64'(cur_edge);
    endfunction

    function automatic logic [63:0] rows_in_range(input logic [63:0] start,
                                                  input logic [63:0] extent,
                                                  input logic [63:0] edge_n);
        if (start >= extent)
            return 64'd0;
        return (extent - start < edge_n) ? extent - start : edge_n;
    endfunction

    function automatic void predict_rows(input logic [15:0] bx, input logic [15:0] by,
                                         input logic [15:0] bz, input bit known,
                                         input logic [vbg_pkg::SRC_W-1:0] k_src,
                                         input logic [vbg_pkg::LEN_W-1:0] k_len);
        logic [63:0] edge_n, x0, y0, z0, nx, ny, nz, base;
        int          lx, ly, first;
        bit          copy;
        row_t        r;
        edge_n = edge_used();
        x0 = 64'(bx) * edge_n;
        y0 = 64'(by) * edge_n;
        z0 = 64'(bz) * edge_n;
        nx = rows_in_range(x0, 64'(cur_sx), edge_n);
        ny = rows_in_range(y0, 64'(cur_sy), edge_n);
        nz = rows_in_range(z0, 64'(cur_sz), edge_n);
        first = rows_due.size();
        for (lx = 0; lx < int'(edge_n); lx++)
        begin
            base = 64'd0;
            if (64'(lx) < nx)
                base = (x0 + 64'(lx)) * 64'(cur_sy) * 64'(cur_sz) + y0 * 64'(cur_sz) + z0;
            for (ly = 0; ly < int'(edge_n); ly++)
            begin
                copy = (64'(lx) < nx) && (64'(ly) < ny) && (nz != 64'd0);
                r.src  = copy ? vbg_pkg::SRC_W'(base + 64'(ly) * 64'(cur_sz)) : '0;
                r.dst  = vbg_pkg::DST_W'(64'(lx) * edge_n * edge_n + 64'(ly) * edge_n);
                r.len  = copy ? nz[vbg_pkg::LEN_W-1:0] : '0;
                r.last = (64'(lx) == edge_n - 1) && (64'(ly) == edge_n - 1);
                rows_due.push_back(r);
            end
        end
        if (known)
        begin
            rows_due[first].src = k_src;
            rows_due[first].len = k_len;
        end
    endfunction

    function automatic int pick_gap();
        if (no_idle)
            return 0;
        return $urandom_range(0, 17);
    endfunction

    function automatic logic [15:0] pick_size();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            return 16'd0;
        if (pick < 3)
            return 16'hFFFF;
        if (pick < 7)
            return 16'($urandom);
        return 16'($urandom_range(1, 24));
    endfunction

    function automatic logic [15:0] pick_edge();
        logic [15:0] v;
        v = 16'($urandom);
        if ($urandom_range(0, 9) == 0)
            v[3:0] = ($urandom_range(0, 1) == 0) ? 4'd0 : 4'($urandom_range(9, 15));
        else
            v[3:0] = 4'($urandom_range(1, MAX_EDGE));
        return v;
    endfunction

    function automatic logic [15:0] pick_coord(input logic [15:0] extent);
        int e, span;
        e = int'(edge_used());
        span = (int'(extent) + e - 1) / e;
        if ($urandom_range(0, 9) < 8)
            return 16'($urandom_range(0, span));
        return 16'($urandom);
    endfunction

    task automatic note_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        $display("mismatch %s: got %h want %h (row %0d)", what, got, want, rows_checked);
        errors++;
    endtask

    task automatic write_reg(input logic [vbg_pkg::CFG_IDX_W-1:0] idx,
                             input logic [vbg_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            vbg_pkg::REG_SIZE_X:   cur_sx = data;
            vbg_pkg::REG_SIZE_Y:   cur_sy = data;
            vbg_pkg::REG_SIZE_Z:   cur_sz = data;
            vbg_pkg::REG_EDGE_LEN: cur_edge = data[3:0];
            default:      ;
        endcase
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain_rows();
        in_valid <= 1'b0;
        @(posedge clk);
        while (rows_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic apply_setting(input logic [15:0] sx, input logic [15:0] sy,
                                 input logic [15:0] sz, input logic [15:0] ed);
        drain_rows();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(vbg_pkg::REG_SIZE_X, sx);
        write_reg(vbg_pkg::REG_SIZE_Y, sy);
        write_reg(vbg_pkg::REG_SIZE_Z, sz);
        write_reg(vbg_pkg::REG_EDGE_LEN, ed);
        // unmapped index, must be ignored
        write_reg(vbg_pkg::CFG_IDX_W'(vbg_pkg::REG_EDGE_LEN + 1 + $urandom_range(0, 11)),
                  16'($urandom));
        settings_used++;
    endtask

    task automatic send_block(input logic [15:0] bx, input logic [15:0] by,
                              input logic [15:0] bz, input bit known,
                              input logic [vbg_pkg::SRC_W-1:0] k_src,
                              input logic [vbg_pkg::LEN_W-1:0] k_len);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        blk_x     <= bx;
        blk_y     <= by;
        blk_z     <= bz;
        tag_known <= known;
        tag_src   <= k_src;
        tag_len   <= k_len;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            predict_rows(blk_x, blk_y, blk_z, tag_known, tag_src, tag_len);
            blocks_sent++;
        end
    end

    always @(posedge clk)
    begin : check_rows
        row_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (rows_due.size() == 0)
                note_mismatch("descriptor with none due", 64'(src_index), 64'd0);
            else
            begin
                want = rows_due.pop_front();
                if (src_index !== want.src)
                    note_mismatch("src_index", 64'(src_index), 64'(want.src));
                if (dst_offset !== want.dst)
                    note_mismatch("dst_offset", 64'(dst_offset), 64'(want.dst));
                if (copy_len !== want.len)
                    note_mismatch("copy_len", 64'(copy_len), 64'(want.len));
                if (last_row !== want.last)
                    note_mismatch("last_row", 64'(last_row), 64'(want.last));
                rows_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles, %0d rows due",
                     quiet_cycles, rows_due.size());
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin : receiver
        int w;
        @(posedge rst_n);
        forever
        begin
            w = pick_gap();
            if (w > 0)
            begin
                out_stall <= 1'b1;
                repeat (w) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    initial
    begin : stimulus
        int i, p, k;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        blk_x     <= '0;
        blk_y     <= '0;
        blk_z     <= '0;
        out_stall <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        tag_known <= 1'b0;
        tag_src   <= '0;
        tag_len   <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < PLAN_LEN; i++)
        begin
            if (plan[i].set_cfg)
                apply_setting(plan[i].sx, plan[i].sy, plan[i].sz, plan[i].ed);
            send_block(plan[i].bx, plan[i].by, plan[i].bz,
                       plan[i].known, plan[i].k_src, plan[i].k_len);
        end

        for (p = 0; p < PHASES; p++)
        begin
            no_idle = (p % 4 == 3);
            if (p == 0)
                apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd8);
            else if (p == 1)
                apply_setting(16'd1, 16'd1, 16'd1, 16'd1);
            else
                apply_setting(pick_size(), pick_size(), pick_size(), pick_edge());
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                if ($urandom_range(0, 29) == 0)
                    drain_rows();
                send_block(pick_coord(cur_sx), pick_coord(cur_sy), pick_coord(cur_sz),
                           1'b0, '0, '0);
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (rows_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES + 2) @(posedge clk);

        $display("summary: %0d block requests over %0d register settings", blocks_sent,
                 settings_used);
        $display("summary: %0d row descriptors compared, %0d mismatches", rows_checked, errors);
        if (errors == 0 && rows_due.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: files.f
hdl/vbg_pkg.sv
hdl/vbg_front.sv
hdl/vbg_queue.sv
hdl/vbg_back.sv
hdl/volume_block_gather_address_gen_top.sv
bench/tb_volume_block_gather_address_gen_top.sv
